// ===== rtl/core/sad_pkg.sv =====
package sad_pkg;

  // capacity of the queue
  localparam int DEPTH = 16;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = PTR_W + 2;

  typedef logic [PTR_W-1:0] ptr_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [SUM_W-1:0] sum_t;

  // request codes
  localparam logic [1:0] REQ_INS_HEAD = 2'd0;
  localparam logic [1:0] REQ_INS_TAIL = 2'd1;
  localparam logic [1:0] REQ_RM_HEAD  = 2'd2;
  localparam logic [1:0] REQ_RM_TAIL  = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [31:0] data;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] removed_value;
    logic [4:0]         occupancy;
  } out_beat_t;

  // fold a ring index that may exceed the capacity once
  function automatic ptr_t wrap_ptr(sum_t s);
    sum_t r;
    r = (s >= sum_t'(DEPTH)) ? s - sum_t'(DEPTH) : s;
    return r[PTR_W-1:0];
  endfunction

endpackage

// ===== rtl/core/shifting_array_deque.sv =====
// double-ended queue of 32-bit signed entries, capacity sad_pkg::DEPTH
//
// input channel: a request beat (req_type, data) is taken at a rising edge
// where start is high and busy is low. req_type selects insert at head,
// insert at tail, remove from head or remove from tail.
// result channel: every request gives exactly one result beat on out_beat,
// shown for one cycle with out_valid high, in the cycle right after the
// request was taken. the receiver cannot stall, so results are never held.
// a new request may be issued every cycle; the
// entry store is a ring in a one-port-write, one-port-read memory whose
// registered read lands in the result cycle, so no interlock is needed.
// removal from an empty queue returns status empty, insert into a full
// queue returns status full; neither changes anything. removed_value is
// zero except on a successful removal. occupancy is the count afterwards.
// reset (rst_n low, synchronous) empties the queue and drops any pending
// result; busy is high while reset is applied and low from then on.
module shifting_array_deque (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  sad_pkg::in_beat_t   in_beat,
  output logic                out_valid,
  output sad_pkg::out_beat_t  out_beat
);

  import sad_pkg::*;

  // control state
  ptr_t       head_r, head_nxt;
  cnt_t       count_r, count_nxt;
  logic       busy_r;
  logic       out_valid_r;
  logic [1:0] status_r, status_nxt;
  logic       take_r, take_nxt;

  // decode of the current request
  logic       acc;
  logic       full, empty;
  logic       ram_we, ram_re;
  ptr_t       ram_waddr, ram_raddr;
  logic [31:0] ram_rdata;

  // ring positions around the live region
  ptr_t       head_dec, head_inc, tail_ins, tail_last;
  logic [31:0] cnt_ext;

  assign acc   = start && !busy_r;
  assign full  = (count_r == cnt_t'(DEPTH));
  assign empty = (count_r == '0);

  assign head_dec  = (head_r == '0) ? ptr_t'(DEPTH - 1) : head_r - ptr_t'(1);
  assign head_inc  = wrap_ptr(sum_t'(head_r) + sum_t'(1));
  assign tail_ins  = wrap_ptr(sum_t'(head_r) + sum_t'(count_r));
  // only meaningful when the queue holds something
  assign tail_last = wrap_ptr(sum_t'(head_r) + sum_t'(count_r) - sum_t'(1));

  always_comb begin
    head_nxt   = head_r;
    count_nxt  = count_r;
    status_nxt = ST_OK;
    take_nxt   = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = tail_ins;
    ram_re     = 1'b0;
    ram_raddr  = head_r;
    if (acc) begin
      unique case (in_beat.req_type)
        REQ_INS_HEAD: begin
          if (full) begin
            status_nxt = ST_FULL;
          end else begin
            // new head sits one slot below the old one
            ram_we    = 1'b1;
            ram_waddr = head_dec;
            head_nxt  = head_dec;
            count_nxt = count_r + cnt_t'(1);
          end
        end
        REQ_INS_TAIL: begin
          if (full) begin
            status_nxt = ST_FULL;
          end else begin
            ram_we    = 1'b1;
            ram_waddr = tail_ins;
            count_nxt = count_r + cnt_t'(1);
          end
        end
        REQ_RM_HEAD: begin
          if (empty) begin
            status_nxt = ST_EMPTY;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = head_r;
            take_nxt  = 1'b1;
            head_nxt  = head_inc;
            count_nxt = count_r - cnt_t'(1);
          end
        end
        REQ_RM_TAIL: begin
          if (empty) begin
            status_nxt = ST_EMPTY;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = tail_last;
            take_nxt  = 1'b1;
            count_nxt = count_r - cnt_t'(1);
          end
        end
        default: begin
          status_nxt = ST_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      count_r     <= '0;
      busy_r      <= 1'b1;
      out_valid_r <= 1'b0;
      status_r    <= ST_OK;
      take_r      <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      busy_r      <= 1'b0;
      out_valid_r <= acc;
      status_r    <= status_nxt;
      take_r      <= take_nxt;
    end
  end

  // entry store, read data arrives with the result beat
  sad_ram #(
    .WORDS (DEPTH),
    .DW    (32)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_beat.data),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // occupancy shows the low five bits of the count
  assign cnt_ext = 32'(count_r);

  assign busy                   = busy_r;
  assign out_valid              = out_valid_r;
  assign out_beat.status        = status_r;
  assign out_beat.removed_value = take_r ? $signed(ram_rdata) : 32'sd0;
  assign out_beat.occupancy     = cnt_ext[4:0];

endmodule

// ===== rtl/core/sad_ram.sv =====
module sad_ram #(
  parameter int WORDS = 16,
  parameter int DW    = 32
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((WORDS > 1) ? $clog2(WORDS) : 1)-1:0] waddr,
  input  logic [DW-1:0]                            wdata,
  input  logic                                     re,
  input  logic [((WORDS > 1) ? $clog2(WORDS) : 1)-1:0] raddr,
  output logic [DW-1:0]                            rdata
);

  logic [DW-1:0] mem [WORDS];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/sad_chk.sv =====
module sad_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input sad_pkg::in_beat_t  in_beat,
  input logic               out_valid,
  input sad_pkg::out_beat_t out_beat
);

  import sad_pkg::*;

  // every taken request gives a result beat in the next cycle
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> out_valid)
    else $error("request without result beat");

  // no result beat appears without a request
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !(start && !busy) |=> !out_valid)
    else $error("result beat without request");

  // failed requests (status not ok) return no value
  a_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_beat.status != ST_OK) |-> (out_beat.removed_value == 32'sd0))
    else $error("nonzero value on failed request");

  // an empty report means the queue really is empty
  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_beat.status == ST_EMPTY) |-> (out_beat.occupancy == 5'd0))
    else $error("empty status with nonzero occupancy");

  // a successful insert leaves something in the queue
  a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_beat.req_type == REQ_INS_HEAD ||
                        in_beat.req_type == REQ_INS_TAIL))
    |=> (out_beat.status == ST_FULL || out_beat.occupancy != 5'd0 || DEPTH >= 32))
    else $error("insert left queue empty");

endmodule

bind shifting_array_deque sad_chk u_sad_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_beat   (in_beat),
  .out_valid (out_valid),
  .out_beat  (out_beat)
);

// ===== tb/deque_checker.sv =====
`timescale 1ns / 100ps

module deque_checker
  import sad_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic      busy,
  input  in_beat_t  in_beat,
  input  logic      out_valid,
  input  out_beat_t out_beat,
  output int        mismatch_count,
  output int        results_pending
);

  // shadow copy of the deque
  logic signed [31:0] shadow_slots [DEPTH];
  int                 shadow_fill;
  out_beat_t          expected_results [$];

  initial mismatch_count = 0;
  initial results_pending = 0;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("ERROR @%0t: %s got 0x%08h expected 0x%08h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // apply one request to the shadow deque, return the result it should give
  function automatic out_beat_t apply_deque_request(input in_beat_t req);
    out_beat_t res;
    int        i;
    res.status        = ST_OK;
    res.removed_value = '0;
    case (req.req_type)
      REQ_INS_HEAD: begin
        if (shadow_fill >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          for (i = shadow_fill; i >= 1; i--) shadow_slots[i] = shadow_slots[i-1];
          shadow_slots[0] = req.data;
          shadow_fill++;
        end
      end
      REQ_INS_TAIL: begin
        if (shadow_fill >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          shadow_slots[shadow_fill] = req.data;
          shadow_fill++;
        end
      end
      REQ_RM_HEAD: begin
        if (shadow_fill == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.removed_value = shadow_slots[0];
          for (i = 0; i + 1 < shadow_fill; i++) shadow_slots[i] = shadow_slots[i+1];
          shadow_slots[shadow_fill-1] = '0;
          shadow_fill--;
        end
      end
      default: begin
        if (shadow_fill == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.removed_value = shadow_slots[shadow_fill-1];
          shadow_slots[shadow_fill-1] = '0;
          shadow_fill--;
        end
      end
    endcase
    res.occupancy = 5'(shadow_fill);
    return res;
  endfunction

  always @(posedge clk) begin
    out_beat_t want;
    if (!rst_n) begin
      foreach (shadow_slots[k]) shadow_slots[k] = '0;
      shadow_fill = 0;
      expected_results.delete();
    end else begin
      // result beat first: it belongs to an earlier request
      if (out_valid) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result beat with nothing pending", 32'(out_beat), '0);
        end else begin
          want = expected_results.pop_front();
          if (out_beat.status !== want.status)
            report_mismatch("status", 32'(out_beat.status), 32'(want.status));
          if (out_beat.removed_value !== want.removed_value)
            report_mismatch("removed_value", out_beat.removed_value, want.removed_value);
          if (out_beat.occupancy !== want.occupancy)
            report_mismatch("occupancy", 32'(out_beat.occupancy), 32'(want.occupancy));
        end
      end
      if (start && !busy) expected_results.push_back(apply_deque_request(in_beat));
    end
    results_pending <= expected_results.size();
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import sad_pkg::*;

  // cycles with no beat moving on either side before the run is abandoned
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_REQUESTS = 1130;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_beat_t  in_beat = '0;
  logic      out_valid;
  out_beat_t out_beat;
  int        mismatch_count;
  int        results_pending;
  int        idle_cycles = 0;

  // stimulus shaping state
  int        insert_bias;   // percent chance that a random request inserts
  bit        quiet_stretch; // no gaps between requests while set

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  shifting_array_deque dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_beat   (in_beat),
    .out_valid (out_valid),
    .out_beat  (out_beat)
  );

  // watches both channels, keeps its own deque and compares every result
  deque_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_beat         (in_beat),
    .out_valid       (out_valid),
    .out_beat        (out_beat),
    .mismatch_count  (mismatch_count),
    .results_pending (results_pending)
  );

  // watchdog: restarts on any accepted beat, gives up after a long silence
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired after %0d idle cycles", idle_cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // mostly back to back, some short pauses, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (quiet_stretch) return 0;
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // mostly full-range random words, sometimes the corner values
  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(19))
      0:       return 32'sh7fff_ffff;
      1:       return 32'sh8000_0000;
      2:       return '1;
      3:       return '0;
      default: return $urandom;
    endcase
  endfunction

  // hold start high until the beat is taken, then optionally drop it for a gap
  task automatic send_request(input logic [1:0] kind, input logic signed [31:0] value,
                              input int gap);
    in_beat_t b;
    b.req_type = kind;
    b.data     = value;
    start   <= 1'b1;
    in_beat <= b;
    do @(posedge clk); while (busy);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin
    logic [1:0] kind;
    int         i;

    quiet_stretch = 1'b0;
    insert_bias   = 50;

    // reset applied once, at the start of the run
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: removals while empty, both ends
    send_request(REQ_RM_HEAD, 32'sh1234_5678, 0);
    send_request(REQ_RM_TAIL, '1, 1);

    // fill to capacity from both ends, corner values first
    for (i = 0; i < DEPTH; i++) begin
      kind = (i % 2 == 0) ? REQ_INS_HEAD : REQ_INS_TAIL;
      case (i)
        0:       send_request(kind, 32'sh7fff_ffff, 0);
        1:       send_request(kind, 32'sh8000_0000, 0);
        2:       send_request(kind, '1, 0);
        3:       send_request(kind, '0, 2);
        default: send_request(kind, $urandom, 0);
      endcase
    end

    // inserts into a full deque at both ends
    send_request(REQ_INS_HEAD, 32'sh5a5a_5a5a, 0);
    send_request(REQ_INS_TAIL, 32'sha5a5_a5a5, 0);

    // one removal from each end
    send_request(REQ_RM_HEAD, '0, 0);
    send_request(REQ_RM_TAIL, '0, 1);

    // random part: phases that lean toward filling, draining or neither so the
    // occupancy sweeps between empty and full many times
    for (i = 0; i < RANDOM_REQUESTS; i++) begin
      if (i % 40 == 0) begin
        case ($urandom_range(2))
          0:       insert_bias = 20;
          1:       insert_bias = 50;
          default: insert_bias = 80;
        endcase
        quiet_stretch = ($urandom_range(3) == 0);
      end
      if ($urandom_range(9) == 0) begin
        kind = 2'($urandom_range(3));
      end else if ($urandom_range(99) < insert_bias) begin
        kind = $urandom_range(1) ? REQ_INS_TAIL : REQ_INS_HEAD;
      end else begin
        kind = $urandom_range(1) ? REQ_RM_TAIL : REQ_RM_HEAD;
      end
      send_request(kind, pick_value(), pick_gap());
    end
    start <= 1'b0;

    // drain: wait for the last results, then a few spare cycles
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    if (mismatch_count == 0 && results_pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/sad_pkg.sv
rtl/core/sad_ram.sv
rtl/core/shifting_array_deque.sv
rtl/core/sad_chk.sv
tb/deque_checker.sv
tb/testbench.sv
